// ===== rtl/kcbb_pkg.sv =====
// Shared types and constants of the key color bounding box block.
`timescale 1ns / 1ps

package kcbb_pkg;

    localparam int PIX_W  = 32;
    localparam int ROW_W  = 12;
    localparam int COL_W  = 12;
    localparam int CNT_W  = 25;
    localparam int CFG_W  = 32;
    localparam int CFG_IDX_W = 1;

    // Saturation limit of the match count.
    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(25'd16777216);

    // Register reset values.
    localparam logic [PIX_W-1:0] KEY_COLOR_RESET = 32'hFFFF_0000;
    localparam logic [CNT_W-1:0] MIN_COUNT_RESET = CNT_W'(25);

    // Register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_COLOR = 1'b0,
        CFG_MIN_COUNT = 1'b1
    } t_cfg_idx;

    // One pixel after the key compare.
    typedef struct packed {
        logic             hit;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_hit;

endpackage

// ===== rtl/kcbb_pix_if.sv =====
// Pixel channel interface: valid, ready and one pixel with its position.
`timescale 1ns / 1ps

interface kcbb_pix_if;
    import kcbb_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             frame_last;

    modport source (output valid, pixel_value, row, col, frame_last, input ready);
    modport sink   (input valid, pixel_value, row, col, frame_last, output ready);
endinterface

// ===== rtl/kcbb_res_if.sv =====
// Result channel interface: valid, ready and one frame result.
`timescale 1ns / 1ps

interface kcbb_res_if;
    import kcbb_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] match_count;
    logic             present;
    logic             any_match;
    logic [ROW_W-1:0] box_row_min;
    logic [ROW_W-1:0] box_row_max;
    logic [COL_W-1:0] box_col_min;
    logic [COL_W-1:0] box_col_max;

    modport source (output valid, match_count, present, any_match, box_row_min,
                    box_row_max, box_col_min, box_col_max, input ready);
    modport sink   (input valid, match_count, present, any_match, box_row_min,
                    box_row_max, box_col_min, box_col_max, output ready);
endinterface

// ===== rtl/kcbb_front.sv =====
// Input register stage: takes a pixel and registers its key color match.
`timescale 1ns / 1ps

module kcbb_front #(
    parameter int MAX_ROWS = 4096,
    parameter int MAX_COLS = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    kcbb_pix_if.sink                  i_pix,
    input  logic [kcbb_pkg::PIX_W-1:0] i_key_color,
    input  logic                      i_advance,
    output logic                      o_valid,
    output kcbb_pkg::t_hit            o_hit
);
    import kcbb_pkg::*;

    logic r_valid;
    t_hit r_hit;
    t_hit n_hit;
    logic w_inside;

    // The stage takes a new pixel when empty or when its content moves on.
    assign i_pix.ready = !r_valid || i_advance;

    // A pixel outside the frame never matches.
    assign w_inside = (32'(i_pix.row) < 32'(MAX_ROWS)) && (32'(i_pix.col) < 32'(MAX_COLS));

    always_comb begin
        n_hit.hit  = w_inside && (i_pix.pixel_value == i_key_color);
        n_hit.row  = i_pix.row;
        n_hit.col  = i_pix.col;
        n_hit.last = i_pix.frame_last;
    end

    // Valid flag of the stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_valid <= i_pix.valid;
        end
    end

    // Payload register, loaded on each transaction.
    always_ff @(posedge i_clk) begin
        if (i_pix.valid && i_pix.ready) begin
            r_hit <= n_hit;
        end
    end

    assign o_valid = r_valid;
    assign o_hit   = r_hit;
endmodule

// ===== rtl/kcbb_accum.sv =====
// Frame accumulator: count and bounding box, plus the result register.
`timescale 1ns / 1ps

module kcbb_accum (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  kcbb_pkg::t_hit             i_hit,
    input  logic [kcbb_pkg::CNT_W-1:0] i_min_count,
    output logic                       o_advance,
    kcbb_res_if.source                 o_res
);
    import kcbb_pkg::*;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_seen, n_seen;
    logic [ROW_W-1:0] r_rmin, n_rmin, r_rmax, n_rmax;
    logic [COL_W-1:0] r_cmin, n_cmin, r_cmax, n_cmax;
    logic             r_out_valid;

    // An item moves on unless it ends a frame while the result is still held.
    assign o_advance = i_valid && (!i_hit.last || !r_out_valid || o_res.ready);

    // Next frame state with the current pixel taken into account.
    always_comb begin
        n_cnt  = r_cnt;
        n_seen = r_seen;
        n_rmin = r_rmin;
        n_rmax = r_rmax;
        n_cmin = r_cmin;
        n_cmax = r_cmax;
        if (i_hit.hit) begin
            if (r_cnt < COUNT_CAP) begin
                n_cnt = r_cnt + CNT_W'(1);
            end
            n_seen = 1'b1;
            if (!r_seen) begin
                n_rmin = i_hit.row;
                n_rmax = i_hit.row;
                n_cmin = i_hit.col;
                n_cmax = i_hit.col;
            end else begin
                if (i_hit.row < r_rmin) n_rmin = i_hit.row;
                if (i_hit.row > r_rmax) n_rmax = i_hit.row;
                if (i_hit.col < r_cmin) n_cmin = i_hit.col;
                if (i_hit.col > r_cmax) n_cmax = i_hit.col;
            end
        end
    end

    // Frame state; it clears after the last pixel of a frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_seen <= 1'b0;
            r_rmin <= '0;
            r_rmax <= '0;
            r_cmin <= '0;
            r_cmax <= '0;
        end else if (o_advance) begin
            if (i_hit.last) begin
                r_cnt  <= '0;
                r_seen <= 1'b0;
                r_rmin <= '0;
                r_rmax <= '0;
                r_cmin <= '0;
                r_cmax <= '0;
            end else begin
                r_cnt  <= n_cnt;
                r_seen <= n_seen;
                r_rmin <= n_rmin;
                r_rmax <= n_rmax;
                r_cmin <= n_cmin;
                r_cmax <= n_cmax;
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance && i_hit.last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; the box reads as zero when nothing matched.
    always_ff @(posedge i_clk) begin
        if (o_advance && i_hit.last) begin
            o_res.match_count <= n_cnt;
            o_res.present     <= (n_cnt >= i_min_count);
            o_res.any_match   <= n_seen;
            o_res.box_row_min <= n_seen ? n_rmin : '0;
            o_res.box_row_max <= n_seen ? n_rmax : '0;
            o_res.box_col_min <= n_seen ? n_cmin : '0;
            o_res.box_col_max <= n_seen ? n_cmax : '0;
        end
    end

    assign o_res.valid = r_out_valid;
endmodule

// ===== rtl/key_color_bounding_box_core.sv =====
// Top level of the key color bounding box block.
//
//  Channel  | Dir | Handshake   | Payload
//  ---------+-----+-------------+------------------------------------------------
//  i_pix    | in  | valid/ready | pixel_value, row, col, frame_last
//  o_res    | out | valid/ready | match_count, present, any_match, box row/col
//  i_cfg_*  | in  | write only  | register index and data
//
// One pixel per cycle is accepted while no held result stalls the input;
// a result passes the input register and then the result register. Reset is
// synchronous, clears frame state and valid flags, presets config registers.
// A result held by the sink stalls input only when a frame-ending pixel
// reaches the accumulator; other pixels keep flowing.
`timescale 1ns / 1ps

module key_color_bounding_box_core #(
    parameter int MAX_ROWS = 4096,
    parameter int MAX_COLS = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    kcbb_pix_if.sink                       i_pix,
    kcbb_res_if.source                     o_res,
    input  logic                           i_cfg_we,
    input  logic [kcbb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kcbb_pkg::CFG_W-1:0]     i_cfg_data
);
    import kcbb_pkg::*;

    logic [PIX_W-1:0] r_key_color;
    logic [CNT_W-1:0] r_min_count;
    logic             w_valid;
    logic             w_advance;
    t_hit             w_hit;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_color <= KEY_COLOR_RESET;
            r_min_count <= MIN_COUNT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY_COLOR: r_key_color <= i_cfg_data;
                CFG_MIN_COUNT: r_min_count <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    kcbb_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_key_color (r_key_color),
        .i_advance   (w_advance),
        .o_valid     (w_valid),
        .o_hit       (w_hit)
    );

    kcbb_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid),
        .i_hit       (w_hit),
        .i_min_count (r_min_count),
        .o_advance   (w_advance),
        .o_res       (o_res)
    );
endmodule

// ===== rtl/kcbb_checker.sv =====
// Port-level checks on the key color bounding box block, bound to the top.
`timescale 1ns / 1ps

module kcbb_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [kcbb_pkg::CNT_W-1:0] i_match_count,
    input logic                       i_any_match,
    input logic [kcbb_pkg::ROW_W-1:0] i_row_min,
    input logic [kcbb_pkg::ROW_W-1:0] i_row_max,
    input logic [kcbb_pkg::COL_W-1:0] i_col_min,
    input logic [kcbb_pkg::COL_W-1:0] i_col_max
);
    import kcbb_pkg::*;

    // A held result stays valid and keeps its count, row minimum and column maximum until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_match_count)
        && $stable(i_row_min) && $stable(i_col_max))
        else $error("result changed while stalled");

    // No result right after reset.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A frame without matches has an empty, zero box.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_any_match |-> i_match_count == '0 && i_row_min == '0
        && i_row_max == '0 && i_col_min == '0 && i_col_max == '0)
        else $error("nonzero box or count without a match");

    // A frame with matches has a nonzero count and an ordered box.
    a_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_any_match |-> i_match_count != '0
        && i_row_min <= i_row_max && i_col_min <= i_col_max)
        else $error("bounding box out of order");
endmodule

bind key_color_bounding_box_core kcbb_checker u_kcbb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_match_count (o_res.match_count),
    .i_any_match   (o_res.any_match),
    .i_row_min     (o_res.box_row_min),
    .i_row_max     (o_res.box_row_max),
    .i_col_min     (o_res.box_col_min),
    .i_col_max     (o_res.box_col_max)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench of the key color bounding box block.
`timescale 1ns / 1ps

module tb_top;
    import kcbb_pkg::*;

    localparam int FRAME_ROWS   = 4096;
    localparam int FRAME_COLS   = 4096;
    localparam int SETTLE       = 4;    // two pipeline stages plus margin
    localparam int RANDOM_ITEMS = 1400;
    localparam int PHASE_ITEMS  = 120;

    typedef struct packed {
        logic [CNT_W-1:0] match_count;
        logic             present;
        logic             any_match;
        logic [ROW_W-1:0] box_row_min;
        logic [ROW_W-1:0] box_row_max;
        logic [COL_W-1:0] box_col_min;
        logic [COL_W-1:0] box_col_max;
    } t_frame_box;

    typedef enum logic {
        ROW_PIXEL,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind        kind;
        t_cfg_idx         idx;
        logic [PIX_W-1:0] data;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
        bit               typed;
        t_frame_box       want;
    } t_stim_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    kcbb_pix_if pix_if ();
    kcbb_res_if res_if ();

    key_color_bounding_box_core #(
        .MAX_ROWS(FRAME_ROWS),
        .MAX_COLS(FRAME_COLS)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (pix_if),
        .o_res     (res_if),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // Predictor copy of the registers and the frame accumulator.
    logic [PIX_W-1:0] key_reg;
    logic [CNT_W-1:0] min_reg;
    logic [CNT_W-1:0] hits;
    logic             seen;
    logic [ROW_W-1:0] lo_row, hi_row;
    logic [COL_W-1:0] lo_col, hi_col;

    t_frame_box pending_boxes[$];
    int         errors = 0;
    bit         calm = 1'b0;
    bit         use_typed = 1'b0;
    t_frame_box typed_box;
    t_stim_row  directed[$];

    // Clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Run limit.
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Updates the accumulator with one pixel; returns 1 and the frame result on the last pixel.
    function automatic bit track_pixel(input logic [PIX_W-1:0] pv, input logic [ROW_W-1:0] r,
                                       input logic [COL_W-1:0] c, input logic last,
                                       output t_frame_box box);
        bit in_frame;
        in_frame = (int'(r) < FRAME_ROWS) && (int'(c) < FRAME_COLS);
        box = '0;
        if (in_frame && pv == key_reg) begin
            if (hits < COUNT_CAP) begin
                hits = hits + CNT_W'(1);
            end
            if (!seen) begin
                lo_row = r;
                hi_row = r;
                lo_col = c;
                hi_col = c;
                seen   = 1'b1;
            end else begin
                if (r < lo_row) lo_row = r;
                if (r > hi_row) hi_row = r;
                if (c < lo_col) lo_col = c;
                if (c > hi_col) hi_col = c;
            end
        end
        if (!last) begin
            return 1'b0;
        end
        box.match_count = hits;
        box.present     = (hits >= min_reg);
        box.any_match   = seen;
        if (seen) begin
            box.box_row_min = lo_row;
            box.box_row_max = hi_row;
            box.box_col_min = lo_col;
            box.box_col_max = hi_col;
        end
        hits   = '0;
        seen   = 1'b0;
        lo_row = '0;
        hi_row = '0;
        lo_col = '0;
        hi_col = '0;
        return 1'b1;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // Both channels are watched at the rising edge.
    t_frame_box predicted, oldest;
    bit         frame_done;
    always @(posedge i_clk) begin
        if (i_rst_n && pix_if.valid && pix_if.ready) begin
            frame_done = track_pixel(pix_if.pixel_value, pix_if.row, pix_if.col,
                                     pix_if.frame_last, predicted);
            if (frame_done) begin
                pending_boxes = {pending_boxes, (use_typed ? typed_box : predicted)};
            end
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_boxes.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual count %0d",
                         $time, res_if.match_count);
                errors++;
            end else begin
                oldest = pending_boxes.pop_front();
                check_field("match_count", 32'(oldest.match_count), 32'(res_if.match_count));
                check_field("present", 32'(oldest.present), 32'(res_if.present));
                check_field("any_match", 32'(oldest.any_match), 32'(res_if.any_match));
                check_field("box_row_min", 32'(oldest.box_row_min), 32'(res_if.box_row_min));
                check_field("box_row_max", 32'(oldest.box_row_max), 32'(res_if.box_row_max));
                check_field("box_col_min", 32'(oldest.box_col_min), 32'(res_if.box_col_min));
                check_field("box_col_max", 32'(oldest.box_col_max), 32'(res_if.box_col_max));
            end
        end
    end

    // Result sink: a random stall before each result transaction.
    initial begin : result_sink
        int stall;
        res_if.ready = 1'b0;
        forever begin
            stall = calm ? 0 : $urandom_range(0, 17);
            repeat (stall) begin
                @(negedge i_clk);
                res_if.ready <= 1'b0;
            end
            @(negedge i_clk);
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!(res_if.valid && res_if.ready)) @(posedge i_clk);
        end
    end

    // Offers one pixel after a random gap and holds it until the transaction.
    task automatic send_pixel(input logic [PIX_W-1:0] pv, input logic [ROW_W-1:0] r,
                              input logic [COL_W-1:0] c, input logic last,
                              input bit typed, input t_frame_box want);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 17);
        repeat (gap) begin
            @(negedge i_clk);
            pix_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        pix_if.valid       <= 1'b1;
        pix_if.pixel_value <= pv;
        pix_if.row         <= r;
        pix_if.col         <= c;
        pix_if.frame_last  <= last;
        use_typed = typed;
        typed_box = want;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
    endtask

    // Stops the pixel stream and waits until every result has come and the pipe is empty.
    task automatic wait_drain();
        @(negedge i_clk);
        pix_if.valid <= 1'b0;
        while (pending_boxes.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_KEY_COLOR) begin
            key_reg = data;
        end else begin
            min_reg = data[CNT_W-1:0];
        end
    endtask

    // Appends one row to the directed table.
    function automatic void add_row(input t_stim_row s);
        directed = {directed, s};
    endfunction

    function automatic t_stim_row pix_row(input logic [PIX_W-1:0] pv, input int r, input int c);
        t_stim_row s;
        s.kind  = ROW_PIXEL;
        s.idx   = CFG_KEY_COLOR;
        s.data  = pv;
        s.row   = r[ROW_W-1:0];
        s.col   = c[COL_W-1:0];
        s.last  = 1'b0;
        s.typed = 1'b0;
        s.want  = '0;
        return s;
    endfunction

    // Frame-ending pixel with its result typed in.
    function automatic t_stim_row end_row(input logic [PIX_W-1:0] pv, input int r, input int c,
                                          input int cnt, input bit pres, input bit any,
                                          input int rmin, input int rmax,
                                          input int cmin, input int cmax);
        t_stim_row s;
        s       = pix_row(pv, r, c);
        s.last  = 1'b1;
        s.typed = 1'b1;
        s.want  = '{cnt[CNT_W-1:0], pres, any, rmin[ROW_W-1:0], rmax[ROW_W-1:0],
                    cmin[COL_W-1:0], cmax[COL_W-1:0]};
        return s;
    endfunction

    function automatic t_stim_row cfg_row(input t_cfg_idx idx, input logic [CFG_W-1:0] d);
        t_stim_row s;
        s.kind  = ROW_CFG;
        s.idx   = idx;
        s.data  = d;
        s.row   = '0;
        s.col   = '0;
        s.last  = 1'b0;
        s.typed = 1'b0;
        s.want  = '0;
        return s;
    endfunction

    initial begin : stimulus
        t_stim_row        s;
        int               sent, phase_sent, len, sel;
        bit               wide;
        logic [PIX_W-1:0] pv;
        logic [ROW_W-1:0] base_r, r;
        logic [COL_W-1:0] base_c, c;
        logic [CNT_W-1:0] min_pick;

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        pix_if.valid       = 1'b0;
        pix_if.pixel_value = '0;
        pix_if.row         = '0;
        pix_if.col         = '0;
        pix_if.frame_last  = 1'b0;
        key_reg = KEY_COLOR_RESET;
        min_reg = MIN_COUNT_RESET;
        hits    = '0;
        seen    = 1'b0;
        lo_row  = '0;
        hi_row  = '0;
        lo_col  = '0;
        hi_col  = '0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: single match, no match, box spanning both corners.
        add_row(end_row(32'hFFFF_0000, 0, 0, 1, 0, 1, 0, 0, 0, 0));
        add_row(end_row(32'h0000_0000, 4095, 4095, 0, 0, 0, 0, 0, 0, 0));
        add_row(pix_row(32'hFFFF_0000, 4095, 0));
        add_row(pix_row(32'hFFFF_0000, 0, 4095));
        add_row(pix_row(32'hFFFF_0001, 2048, 2048));
        add_row(end_row(32'hFFFF_0000, 7, 9, 3, 0, 1, 0, 4095, 0, 4095));
        // Zero minimum: present even with no match.
        add_row(cfg_row(CFG_MIN_COUNT, 32'd0));
        add_row(cfg_row(CFG_KEY_COLOR, 32'hFFFF_FFFF));
        add_row(end_row(32'h0000_0000, 100, 200, 0, 1, 0, 0, 0, 0, 0));
        add_row(end_row(32'hFFFF_FFFF, 4095, 4095, 1, 1, 1, 4095, 4095, 4095, 4095));
        // Minimum above the count limit: never present.
        add_row(cfg_row(CFG_MIN_COUNT, 32'hFFFF_FFFF));
        add_row(cfg_row(CFG_KEY_COLOR, 32'h0000_0000));
        add_row(pix_row(32'h0000_0000, 5, 6));
        add_row(end_row(32'h0000_0000, 5, 6, 2, 0, 1, 5, 5, 6, 6));
        // Count exactly at the minimum, then a frame ending on a miss.
        add_row(cfg_row(CFG_MIN_COUNT, 32'd2));
        add_row(cfg_row(CFG_KEY_COLOR, 32'hA5A5_5A5A));
        add_row(pix_row(32'hA5A5_5A5A, 10, 20));
        add_row(pix_row(32'h5A5A_A5A5, 0, 0));
        add_row(end_row(32'hA5A5_5A5A, 3, 30, 2, 1, 1, 3, 10, 20, 30));
        add_row(pix_row(32'hA5A5_5A5A, 1, 1));
        add_row(end_row(32'h0000_0000, 4000, 4000, 1, 0, 1, 1, 1, 1, 1));

        foreach (directed[i]) begin
            s = directed[i];
            if (s.kind == ROW_CFG) begin
                wait_drain();
                write_reg(s.idx, s.data);
            end else begin
                send_pixel(s.data, s.row, s.col, s.last, s.typed, s.want);
            end
        end

        // Random phases: new settings, then frames in which half the pixels are sent with the key.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_drain();
            calm = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 4);
            case (sel)
                0: pv = 32'h0000_0000;
                1: pv = 32'hFFFF_FFFF;
                2: pv = KEY_COLOR_RESET;
                default: pv = $urandom;
            endcase
            write_reg(CFG_KEY_COLOR, pv);
            sel = $urandom_range(0, 5);
            case (sel)
                0: min_pick = '0;
                1: min_pick = '1;
                2: min_pick = COUNT_CAP;
                3: min_pick = 25'd1;
                4: min_pick = CNT_W'($urandom);
                default: min_pick = CNT_W'($urandom_range(0, 12));
            endcase
            write_reg(CFG_MIN_COUNT, {7'($urandom_range(0, 127)), min_pick});

            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS) begin
                len  = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 10);
                wide = ($urandom_range(0, 2) == 0);
                case ($urandom_range(0, 3))
                    0: begin base_r = '0; base_c = '1 - 12'd15; end
                    1: begin base_r = '1 - 12'd15; base_c = '0; end
                    default: begin base_r = ROW_W'($urandom_range(0, 4080));
                                   base_c = COL_W'($urandom_range(0, 4080)); end
                endcase
                for (int k = 0; k < len; k++) begin
                    sel = $urandom_range(0, 9);
                    if (sel < 5) begin
                        pv = key_reg;
                    end else if (sel < 7) begin
                        pv = key_reg ^ (32'h1 << $urandom_range(0, 31));
                    end else begin
                        pv = $urandom;
                    end
                    if (wide) begin
                        r = ROW_W'($urandom_range(0, 4095));
                        c = COL_W'($urandom_range(0, 4095));
                    end else begin
                        r = base_r + 12'($urandom_range(0, 15));
                        c = base_c + 12'($urandom_range(0, 15));
                    end
                    send_pixel(pv, r, c, (k == len - 1), 1'b0, '0);
                    phase_sent++;
                end
            end
            sent += phase_sent;
        end

        wait_drain();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
